### sv/zzr_pkg.sv
`default_nettype none

package zzr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int DATA_WIDTH  = 32;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int DIM_W       = 3;
  localparam int CFG_W       = 4;
  localparam int DIAG_W      = 4;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } zzr_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             diag_end;
    logic             last;
  } zzr_pos_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [CFG_W-1:0] clamp_cnt(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] res;
    begin
      if (v == '0) begin
        res = CFG_W'(1);
      end else if (v > maxv) begin
        res = maxv;
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

  // smallest row on diagonal t
  function automatic logic [DIM_W-1:0] diag_rmin(input logic [DIAG_W-1:0] t,
                                                  input logic [CFG_W-1:0] cols);
    logic [DIAG_W-1:0] d;
    begin
      if (t >= cols) begin
        d = t - cols + DIAG_W'(1);
      end else begin
        d = '0;
      end
      return d[DIM_W-1:0];
    end
  endfunction

  // largest row on diagonal t
  function automatic logic [DIM_W-1:0] diag_rmax(input logic [DIAG_W-1:0] t,
                                                  input logic [CFG_W-1:0] rows);
    logic [DIAG_W-1:0] d;
    begin
      if (t < rows) begin
        d = t;
      end else begin
        d = rows - CFG_W'(1);
      end
      return d[DIM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### sv/zzr_in_if.sv
`default_nettype none

interface zzr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [zzr_pkg::DATA_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

`default_nettype wire

### sv/zzr_out_if.sv
`default_nettype none

interface zzr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [zzr_pkg::DATA_WIDTH-1:0] value;
  logic [zzr_pkg::DIM_W-1:0]             row;
  logic [zzr_pkg::DIM_W-1:0]             col;
  logic                                  diagonal_end;
  logic                                  last;

  modport source (output valid, output value, output row, output col,
                  output diagonal_end, output last, input ready);
  modport sink (input valid, input value, input row, input col,
                input diagonal_end, input last, output ready);
endinterface

`default_nettype wire

### sv/zzr_walk.sv
`default_nettype none

// Zigzag position generator: steps through the diagonals one element per advance.
module zzr_walk (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      advance,
  input  wire logic [zzr_pkg::CFG_W-1:0] rows,
  input  wire logic [zzr_pkg::CFG_W-1:0] cols,
  output zzr_pkg::zzr_pos_t              pos
);

  logic [zzr_pkg::DIAG_W-1:0] diag_r, diag_nxt;
  logic [zzr_pkg::DIM_W-1:0]  row_r, row_nxt;
  logic [zzr_pkg::DIAG_W-1:0] diag_inc;
  logic [zzr_pkg::DIAG_W-1:0] diag_final;
  logic [zzr_pkg::DIAG_W-1:0] col_full;
  logic [zzr_pkg::DIM_W-1:0]  rmin, rmax;
  logic                       at_end;

  always_comb begin
    rmin       = zzr_pkg::diag_rmin(diag_r, cols);
    rmax       = zzr_pkg::diag_rmax(diag_r, rows);
    // even diagonals climb (row falls), odd ones descend
    at_end     = diag_r[0] ? (row_r == rmax) : (row_r == rmin);
    diag_inc   = diag_r + zzr_pkg::DIAG_W'(1);
    diag_final = zzr_pkg::DIAG_W'(rows) + zzr_pkg::DIAG_W'(cols) - zzr_pkg::DIAG_W'(2);
    col_full   = diag_r - zzr_pkg::DIAG_W'(row_r);

    pos.row      = row_r;
    pos.col      = col_full[zzr_pkg::DIM_W-1:0];
    pos.diag_end = at_end;
    pos.last     = at_end && (diag_r == diag_final);
  end

  always_comb begin
    diag_nxt = diag_r;
    row_nxt  = row_r;
    if (start) begin
      diag_nxt = '0;
      row_nxt  = '0;
    end else if (advance) begin
      if (at_end) begin
        diag_nxt = diag_inc;
        row_nxt  = diag_inc[0] ? zzr_pkg::diag_rmin(diag_inc, cols)
                               : zzr_pkg::diag_rmax(diag_inc, rows);
      end else if (diag_r[0]) begin
        row_nxt = row_r + zzr_pkg::DIM_W'(1);
      end else begin
        row_nxt = row_r - zzr_pkg::DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_r <= '0;
      row_r  <= '0;
    end else begin
      diag_r <= diag_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/zigzag_matrix_reorder.sv
// Loading: one element accepted per cycle, nothing emitted until the matrix is complete.
// Once the last element is accepted, the state enters drain and the walker restarts; each
// drain read fills the output register, one result per cycle (one read of the element
// store per cycle) unless stalled. No element is accepted while a matrix drains.
// Synchronous active-low reset clears control, sets both counts to 8; store is not cleared.
`default_nettype none

module zigzag_matrix_reorder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  zzr_in_if.sink                         in_ch,
  zzr_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [zzr_pkg::CFG_W-1:0] cfg_data
);

  zzr_pkg::zzr_state_t state_r, state_nxt;

  logic [zzr_pkg::CFG_W-1:0] row_count_r, col_count_r;
  logic [zzr_pkg::CFG_W-1:0] rows, cols;
  logic [zzr_pkg::CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [zzr_pkg::CNT_W-1:0] cnt_inc;
  logic [zzr_pkg::CNT_W-1:0] total;
  logic [2*zzr_pkg::CFG_W-1:0] prod;
  logic [zzr_pkg::CNT_W-1:0] addr_full;
  logic [zzr_pkg::ADDR_W-1:0] rd_addr;

  logic in_acc, mat_done, rd_en, walk_start;
  logic out_valid_r, out_valid_nxt;

  logic [zzr_pkg::DATA_WIDTH-1:0] store [zzr_pkg::STORE_DEPTH];
  logic [zzr_pkg::DATA_WIDTH-1:0] rd_data_r;
  zzr_pkg::zzr_pos_t pos;
  zzr_pkg::zzr_pos_t out_pos_r;

  always_comb begin
    rows      = zzr_pkg::clamp_cnt(row_count_r, zzr_pkg::CFG_W'(zzr_pkg::MAX_ROWS));
    cols      = zzr_pkg::clamp_cnt(col_count_r, zzr_pkg::CFG_W'(zzr_pkg::MAX_COLS));
    prod      = (2*zzr_pkg::CFG_W)'(rows) * (2*zzr_pkg::CFG_W)'(cols);
    total     = prod[zzr_pkg::CNT_W-1:0];
    cnt_inc   = load_cnt_r + zzr_pkg::CNT_W'(1);
    in_acc    = in_ch.valid && in_ch.ready;
    mat_done  = cnt_inc >= total;
    addr_full = zzr_pkg::CNT_W'(pos.row) * zzr_pkg::CNT_W'(cols)
              + zzr_pkg::CNT_W'(pos.col);
    rd_addr   = addr_full[zzr_pkg::ADDR_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zzr_pkg::ST_LOAD: begin
        if (in_acc && mat_done) state_nxt = zzr_pkg::ST_DRAIN;
      end
      zzr_pkg::ST_DRAIN: begin
        if (rd_en && pos.last) state_nxt = zzr_pkg::ST_LOAD;
      end
      default: state_nxt = zzr_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    case (state_r)
      zzr_pkg::ST_LOAD:  in_ch.ready = 1'b1;
      // the read register is the output stage: read only when it frees up
      zzr_pkg::ST_DRAIN: rd_en = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        rd_en       = 1'b0;
      end
    endcase
  end

  assign walk_start = in_acc && mat_done;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (in_acc) begin
      load_cnt_nxt = mat_done ? '0 : cnt_inc;
    end
    out_valid_nxt = out_valid_r;
    if (rd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  zzr_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (walk_start),
    .advance (rd_en),
    .rows    (rows),
    .cols    (cols),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zzr_pkg::ST_LOAD;
      row_count_r <= zzr_pkg::CFG_W'(8);
      col_count_r <= zzr_pkg::CFG_W'(8);
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          zzr_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
          zzr_pkg::REG_COL_COUNT: col_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // element store: written in load, read in drain, never both in one cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[load_cnt_r[zzr_pkg::ADDR_W-1:0]] <= in_ch.element;
    end
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
      out_pos_r <= pos;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = rd_data_r;
  assign out_ch.row          = out_pos_r.row;
  assign out_ch.col          = out_pos_r.col;
  assign out_ch.diagonal_end = out_pos_r.diag_end;
  assign out_ch.last         = out_pos_r.last;

`ifndef SYNTH
  a_last_ends_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> out_ch.diagonal_end)
    else $error("last element does not close its diagonal");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zzr_pkg::ST_DRAIN) |->
      (zzr_pkg::CFG_W'(pos.row) < rows && zzr_pkg::CFG_W'(pos.col) < cols))
    else $error("zigzag position outside the matrix");

  a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mat_done) |=> (state_r == zzr_pkg::ST_DRAIN && load_cnt_r == '0))
    else $error("completed matrix did not start the drain");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_pos_r)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
